// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each use sits on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/dcpg_pkg.sv =====
`default_nettype none

package dcpg_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_START_X = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_X   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_Y   = 4'd3;

    // Command codes
    localparam logic FUNC_GENERATE = 1'b0;
    localparam logic FUNC_READ     = 1'b1;

    localparam int INDEX_W = 13;
    localparam int POINT_W = 16;

    typedef struct packed {
        logic               func;
        logic [INDEX_W-1:0] point_index;
    } cmd_t;

    typedef struct packed {
        logic signed [POINT_W-1:0] point_x;
        logic signed [POINT_W-1:0] point_y;
        logic                      point_valid;
    } point_t;

endpackage

`default_nettype wire

// ===== src/dragon_curve_point_generator.sv =====
`default_nettype none
// Heighway dragon curve point generator. A generate command (func 0) samples
// the four endpoint registers, writes both endpoints into a point memory of
// 2^ORDER+1 entries and runs ORDER levels of midpoint subdivision in place,
// then returns one acknowledge beat with zero coordinates and point_valid set.
// A read command (func 1) returns the stored point at point_index; an index
// past the last slot returns zero coordinates. point_valid is 0 until the
// first generate completes, and coordinates read before that are undefined.
// A read goes through one memory read and one output load before the result
// beat, and the block takes no new command until that beat is loaded. A
// generate writes both endpoints, then runs five sequencer steps per new
// midpoint (two reads through the single memory read port, difference,
// halving, write back) and ends with the acknowledge. The block accepts no
// other command meanwhile.
// Computed coordinates wrap to COORD_BITS bits in two's complement; the
// output fields carry the low 16 bits of the stored value, sign extended
// when the store is narrower. Configuration writes are always taken
// (cfg_ready is tied high) and only the low 14 bits are kept; indexes past
// the four registers are dropped.
`include "assert_macros.svh"

module dragon_curve_point_generator
    import dcpg_pkg::*;
#(
    parameter int ORDER      = 12,
    parameter int COORD_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // command channel
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire cmd_t                  in_data,
    // result channel
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output point_t                     out_data,
    // configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned SPAN    = 2 ** ORDER;
    localparam int unsigned NPOINTS = SPAN + 1;
    localparam int ADDR_W     = ORDER + 1;
    // Endpoints land unwrapped, so the store must also hold a 14-bit value.
    localparam int STORE_BITS = (COORD_BITS > CFG_DATA_W + 1) ? COORD_BITS : CFG_DATA_W + 1;
    localparam int D_W        = STORE_BITS + 1;
    localparam int E_W        = STORE_BITS + 2;

    localparam logic [ADDR_W-1:0] SPAN_A = ADDR_W'(SPAN);
    localparam logic [ADDR_W-1:0] STEP_LAST = ADDR_W'(2);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_INIT0  = 10'b0000000010,
        S_INIT1  = 10'b0000000100,
        S_RD_A   = 10'b0000001000,
        S_RD_B   = 10'b0000010000,
        S_DIFF   = 10'b0000100000,
        S_HALF   = 10'b0001000000,
        S_WR     = 10'b0010000000,
        S_FINISH = 10'b0100000000,
        S_RD_OUT = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_DATA_W-1:0] start_x_reg, start_y_reg, end_x_reg, end_y_reg;

    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [ADDR_W-1:0] step_reg, step_next;
    logic              turn_neg_reg, turn_neg_next;
    logic              curve_ready_reg, curve_ready_next;
    logic              rd_hit_reg, rd_hit_next;

    logic signed [STORE_BITS-1:0] x0_reg, x0_next, y0_reg, y0_next;
    logic signed [D_W-1:0]        dx_reg, dx_next, dy_reg, dy_next;
    logic signed [E_W-1:0]        hx_reg, hx_next, hy_reg, hy_next;

    logic   out_valid_reg, out_valid_next;
    point_t out_data_reg, out_data_next;

    // point memory, {y, x} per entry
    logic [2*STORE_BITS-1:0] mem [NPOINTS];
    logic [2*STORE_BITS-1:0] rd_data_reg;
    logic                    rd_en, wr_en;
    logic [ADDR_W-1:0]       raddr, waddr;
    logic [2*STORE_BITS-1:0] wdata;

    logic signed [STORE_BITS-1:0] rd_x, rd_y;
    logic signed [E_W-1:0]        ex, ey, hx_calc, hy_calc, sx, sy;
    logic signed [STORE_BITS-1:0] wx, wy;
    logic [ADDR_W-1:0]            idx_adv;
    logic                         in_accept, out_free, index_in_range;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign index_in_range = (32'(in_data.point_index) < 32'(NPOINTS));

    assign rd_x = rd_data_reg[STORE_BITS-1:0];
    assign rd_y = rd_data_reg[2*STORE_BITS-1:STORE_BITS];

    // halve with truncation toward zero: bias negative values by one
    assign ex      = turn_neg_reg ? (E_W'(dx_reg) - E_W'(dy_reg)) : (E_W'(dx_reg) + E_W'(dy_reg));
    assign ey      = turn_neg_reg ? (E_W'(dy_reg) + E_W'(dx_reg)) : (E_W'(dy_reg) - E_W'(dx_reg));
    assign hx_calc = (ex + signed'(E_W'(ex[E_W-1]))) >>> 1;
    assign hy_calc = (ey + signed'(E_W'(ey[E_W-1]))) >>> 1;

    assign sx = E_W'(x0_reg) + hx_reg;
    assign sy = E_W'(y0_reg) + hy_reg;
    assign wx = STORE_BITS'(signed'(sx[COORD_BITS-1:0]));
    assign wy = STORE_BITS'(signed'(sy[COORD_BITS-1:0]));

    assign idx_adv = idx_reg + step_reg;

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        step_next        = step_reg;
        turn_neg_next    = turn_neg_reg;
        curve_ready_next = curve_ready_reg;
        rd_hit_next      = rd_hit_reg;
        x0_next          = x0_reg;
        y0_next          = y0_reg;
        dx_next          = dx_reg;
        dy_next          = dy_reg;
        hx_next          = hx_reg;
        hy_next          = hy_reg;
        rd_en            = 1'b0;
        raddr            = idx_reg;
        wr_en            = 1'b0;
        waddr            = idx_reg;
        wdata            = {wy, wx};
        out_valid_next   = out_valid_reg && out_stall;
        out_data_next    = out_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                raddr = ADDR_W'(in_data.point_index);
                if (in_accept)
                begin
                    if (in_data.func == FUNC_READ)
                    begin
                        rd_en       = index_in_range;
                        rd_hit_next = index_in_range;
                        state_next  = S_RD_OUT;
                    end
                    else
                    begin
                        state_next = S_INIT0;
                    end
                end
            end
            S_INIT0:
            begin
                wr_en         = 1'b1;
                waddr         = '0;
                wdata         = {STORE_BITS'(start_y_reg), STORE_BITS'(start_x_reg)};
                turn_neg_next = 1'b1;
                idx_next      = '0;
                step_next     = SPAN_A;
                state_next    = S_INIT1;
            end
            S_INIT1:
            begin
                wr_en      = 1'b1;
                waddr      = SPAN_A;
                wdata      = {STORE_BITS'(end_y_reg), STORE_BITS'(end_x_reg)};
                state_next = S_RD_A;
            end
            S_RD_A:
            begin
                rd_en      = 1'b1;
                raddr      = idx_reg;
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                rd_en      = 1'b1;
                raddr      = idx_adv;
                x0_next    = rd_x;
                y0_next    = rd_y;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                dx_next       = D_W'(rd_x) - D_W'(x0_reg);
                dy_next       = D_W'(rd_y) - D_W'(y0_reg);
                turn_neg_next = !turn_neg_reg;
                state_next    = S_HALF;
            end
            S_HALF:
            begin
                hx_next    = hx_calc;
                hy_next    = hy_calc;
                state_next = S_WR;
            end
            S_WR:
            begin
                wr_en = 1'b1;
                waddr = idx_reg + (step_reg >> 1);
                wdata = {wy, wx};
                if (idx_adv == SPAN_A)
                begin
                    idx_next = '0;
                    if (step_reg == STEP_LAST)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        step_next  = step_reg >> 1;
                        state_next = S_RD_A;
                    end
                end
                else
                begin
                    idx_next   = idx_adv;
                    state_next = S_RD_A;
                end
            end
            S_FINISH:
            begin
                curve_ready_next = 1'b1;
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.point_x     = '0;
                    out_data_next.point_y     = '0;
                    out_data_next.point_valid = 1'b1;
                    state_next                = S_IDLE;
                end
            end
            S_RD_OUT:
            begin
                // hold the read data until the output slot frees up
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.point_x     = rd_hit_reg ? POINT_W'(rd_x) : '0;
                    out_data_next.point_y     = rd_hit_reg ? POINT_W'(rd_y) : '0;
                    out_data_next.point_valid = curve_ready_reg;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            idx_reg         <= '0;
            step_reg        <= '0;
            turn_neg_reg    <= 1'b1;
            curve_ready_reg <= 1'b0;
            rd_hit_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
            start_x_reg     <= '0;
            start_y_reg     <= '0;
            end_x_reg       <= '0;
            end_y_reg       <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            step_reg        <= step_next;
            turn_neg_reg    <= turn_neg_next;
            curve_ready_reg <= curve_ready_next;
            rd_hit_reg      <= rd_hit_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_START_X: start_x_reg <= cfg_data;
                    CFG_START_Y: start_y_reg <= cfg_data;
                    CFG_END_X:   end_x_reg   <= cfg_data;
                    CFG_END_Y:   end_y_reg   <= cfg_data;
                    default:     ;
                endcase
            end
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        x0_reg       <= x0_next;
        y0_reg       <= y0_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        hx_reg       <= hx_next;
        hy_reg       <= hy_next;
        out_data_reg <= out_data_next;
    end

    // point memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    `ASSERT_IMPLIES(a_accept_only_idle, in_accept, state_reg == S_IDLE, "accept outside idle")
    `ASSERT_IMPLIES(a_wr_in_range, wr_en, waddr <= SPAN_A, "write past last slot")
    `ASSERT_IMPLIES(a_rd_in_range, rd_en, 32'(raddr) < 32'(NPOINTS), "read past last slot")
    `ASSERT_IMPLIES(a_step_pow2,
        state_reg == S_RD_A || state_reg == S_RD_B || state_reg == S_WR,
        $onehot(step_reg) && step_reg != ADDR_W'(1), "subdivision step not a power of two")
    `ASSERT_ALWAYS(a_ack_valid_flag,
        !(out_valid_reg && !out_data_reg.point_valid && curve_ready_reg && !$past(state_reg == S_FINISH)
          && $past(out_valid_reg) == 1'b0 && $past(state_reg == S_RD_OUT)),
        "read result lost the ready flag")

endmodule

`default_nettype wire
